[src/hila_pkg.sv]
// ----------------------------------------------------------------------------
// hila_pkg
// shared constants and types of the leave-out hybrid index accumulator
// ----------------------------------------------------------------------------
package hila_pkg;
  localparam int NUM_SAMPLES = 256;
  localparam int NUM_CHROMS = 32;
  localparam int POS_BITS = 28;
  localparam int SAMPLE_BITS = 8;
  localparam int CHROM_BITS = 5;
  localparam int ADDR_BITS = SAMPLE_BITS + CHROM_BITS;
  localparam int WSUM_BITS = 56;
  localparam int WTOT_BITS = 40;
  localparam int ENTRY_BITS = WSUM_BITS + WTOT_BITS;
  localparam int HI_BITS = 17;
  localparam int QUO_BITS = 18;

  localparam logic [1:0] CMD_ACC = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [WSUM_BITS-1:0] wsum;
    logic [WTOT_BITS-1:0] wtot;
  } entry_t;

  typedef struct packed {
    logic start;
    logic [WSUM_BITS:0] num;
    logic [WTOT_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [QUO_BITS-1:0] quo;
  } div_rsp_t;
endpackage

[src/hila_ram.sv]
// ----------------------------------------------------------------------------
// hila_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module hila_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[src/hila_div.sv]
// ----------------------------------------------------------------------------
// hila_div
// restoring divider, one quotient bit a cycle, quotient capped at its width
// ----------------------------------------------------------------------------
module hila_div import hila_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  localparam int NB = WSUM_BITS + 1;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] num;
  logic [WTOT_BITS:0] rem;
  logic [WTOT_BITS-1:0] den;
  logic [QUO_BITS-1:0] quo;
  logic sat;
  logic busy;
  logic done;
  logic [CW-1:0] cnt;
  logic [WTOT_BITS:0] trial;
  logic [WTOT_BITS+1:0] diff;

  always_comb begin
    trial = {rem[WTOT_BITS-1:0], num[NB-1]};
    diff = {1'b0, trial} - {2'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CW'(NB);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.num;
      den <= req.den;
      rem <= '0;
      quo <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      num <= {num[NB-2:0], 1'b0};
      if (!diff[WTOT_BITS+1]) begin
        rem <= diff[WTOT_BITS:0];
      end else begin
        rem <= trial;
      end
      if (quo[QUO_BITS-1]) begin
        sat <= 1'b1;
      end
      quo <= {quo[QUO_BITS-2:0], ~diff[WTOT_BITS+1]};
    end
  end

  assign rsp = {done, (sat ? {QUO_BITS{1'b1}} : quo)};
endmodule

[src/hybrid_index_leave_out_accumulator.sv]
// ----------------------------------------------------------------------------
// hybrid_index_leave_out_accumulator
// per sample and chromosome length-weighted dosage sums with leave-out query
// ----------------------------------------------------------------------------
// An accumulate reads, modifies and writes the chromosome and sample
// memories (it is skipped when dosage_missing is set); a clear, after its
// accept, writes one chromosome row a cycle with the sample row written
// alongside; a query does two chromosome reads, then runs a 57-step serial
// divider, or skips the divider when the remaining weight is zero. After
// reset a clearing pass zeroes the memories while busy is high. The
// result shows for one cycle with result_valid; the receiver cannot stall it.
module hybrid_index_leave_out_accumulator import hila_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             command,
  input  logic [7:0]             sample_index,
  input  logic [4:0]             chrom_index,
  input  logic [15:0]            dosage,
  input  logic                   dosage_missing,
  input  logic [27:0]            window_start,
  input  logic [27:0]            window_end,
  input  logic [5:0]             exclude_first,
  input  logic [5:0]             exclude_second,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data,
  output logic                   result_valid,
  output logic [7:0]             sample_echo,
  output logic [HI_BITS-1:0]     index_value,
  output logic                   index_missing
);
  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_ACC_RD = 4'd2;
  localparam logic [3:0] ST_ACC_WR = 4'd3;
  localparam logic [3:0] ST_CLR = 4'd4;
  localparam logic [3:0] ST_Q_A = 4'd5;
  localparam logic [3:0] ST_Q_B = 4'd6;
  localparam logic [3:0] ST_Q_C = 4'd7;
  localparam logic [3:0] ST_Q_DIV = 4'd8;

  logic [3:0] state;
  logic use_lengths;
  logic [ADDR_BITS-1:0] init_cnt;
  logic [CHROM_BITS-1:0] clr_cnt;
  logic [SAMPLE_BITS-1:0] smp;
  logic [CHROM_BITS-1:0] chr;
  logic [5:0] exa, exb;
  logic [WSUM_BITS-1:0] prod;
  logic [WTOT_BITS-1:0] len;
  logic [WSUM_BITS-1:0] wsum;
  logic [WTOT_BITS-1:0] wtot;

  logic c_we, s_we;
  logic [ADDR_BITS-1:0] c_addr;
  logic [SAMPLE_BITS-1:0] s_addr;
  entry_t c_wd, s_wd, c_rd, s_rd;
  div_req_t dreq;
  div_rsp_t drsp;

  hila_ram #(.AW(ADDR_BITS), .DW(ENTRY_BITS)) u_chrom (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd)
  );
  hila_ram #(.AW(SAMPLE_BITS), .DW(ENTRY_BITS)) u_sample (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd)
  );
  hila_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign busy = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  logic [WSUM_BITS:0] sum_w;
  logic [WTOT_BITS:0] sum_t;
  logic [WSUM_BITS:0] cs_w;
  logic [WTOT_BITS:0] cs_t;
  logic [WSUM_BITS-1:0] base_w;
  logic [WTOT_BITS-1:0] base_t;
  logic [WSUM_BITS:0] sub_w;
  logic [WTOT_BITS:0] sub_t;

  always_comb begin
    sum_w = {1'b0, s_rd.wsum} + {1'b0, prod};
    sum_t = {1'b0, s_rd.wtot} + {1'b0, len};
    cs_w = {1'b0, c_rd.wsum} + {1'b0, prod};
    cs_t = {1'b0, c_rd.wtot} + {1'b0, len};
    // first leave-out works on the fresh sample row
    base_w = (state == ST_Q_A) ? s_rd.wsum : wsum;
    base_t = (state == ST_Q_A) ? s_rd.wtot : wtot;
    sub_w = {1'b0, base_w} - {1'b0, c_rd.wsum};
    sub_t = {1'b0, base_t} - {1'b0, c_rd.wtot};
  end

  always_comb begin
    c_we = 1'b0;
    s_we = 1'b0;
    c_addr = {smp, chr};
    s_addr = smp;
    c_wd = '0;
    s_wd = '0;
    case (state)
      ST_INIT: begin
        c_we = 1'b1;
        s_we = 1'b1;
        c_addr = init_cnt;
        s_addr = init_cnt[SAMPLE_BITS-1:0];
      end
      ST_IDLE: begin
        c_addr = {sample_index, chrom_index};
        s_addr = sample_index;
        if (start && command == CMD_QUERY) begin
          c_addr = {sample_index, exclude_first[CHROM_BITS-1:0]};
        end
      end
      ST_ACC_WR: begin
        c_we = 1'b1;
        s_we = 1'b1;
        c_wd.wsum = cs_w[WSUM_BITS] ? '1 : cs_w[WSUM_BITS-1:0];
        c_wd.wtot = cs_t[WTOT_BITS] ? '1 : cs_t[WTOT_BITS-1:0];
        s_wd.wsum = sum_w[WSUM_BITS] ? '1 : sum_w[WSUM_BITS-1:0];
        s_wd.wtot = sum_t[WTOT_BITS] ? '1 : sum_t[WTOT_BITS-1:0];
      end
      ST_CLR: begin
        c_we = 1'b1;
        s_we = 1'b1;
        c_addr = {smp, clr_cnt};
      end
      ST_Q_A: begin
        c_addr = {smp, exb[CHROM_BITS-1:0]};
      end
      default: begin
      end
    endcase
  end

  logic [28:0] diffp;
  assign diffp = {1'b0, window_end} - {1'b0, window_start};

  logic exa_on, exb_on;
  assign exa_on = !exa[5];
  assign exb_on = !exb[5] && (exb != exa);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      init_cnt <= '0;
      use_lengths <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        use_lengths <= cfg_data;
      end
      case (state)
        ST_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            case (command)
              CMD_ACC: begin
                if (!dosage_missing) begin
                  state <= ST_ACC_RD;
                end
              end
              CMD_QUERY: state <= ST_Q_A;
              CMD_CLEAR: begin
                state <= ST_CLR;
                clr_cnt <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ACC_RD: state <= ST_ACC_WR;
        ST_ACC_WR: state <= ST_IDLE;
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_Q_A: state <= ST_Q_B;
        ST_Q_B: state <= ST_Q_C;
        ST_Q_C: begin
          if (wtot == '0) begin
            state <= ST_IDLE;
            result_valid <= 1'b1;
          end else begin
            state <= ST_Q_DIV;
          end
        end
        ST_Q_DIV: begin
          if (drsp.done) begin
            state <= ST_IDLE;
            result_valid <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dreq.start <= 1'b0;
    case (state)
      ST_IDLE: begin
        smp <= sample_index;
        chr <= chrom_index;
        exa <= exclude_first;
        exb <= exclude_second;
        len <= WTOT_BITS'(1);
        if (use_lengths && !diffp[28] && diffp != '0) begin
          len <= WTOT_BITS'(diffp[27:0]);
        end
        if (use_lengths && !diffp[28] && diffp != '0) begin
          prod <= WSUM_BITS'(dosage * diffp[27:0]);
        end else begin
          prod <= WSUM_BITS'(dosage);
        end
      end
      ST_Q_A: begin
        wsum <= s_rd.wsum;
        wtot <= s_rd.wtot;
        if (exa_on) begin
          wsum <= sub_w[WSUM_BITS] ? '0 : sub_w[WSUM_BITS-1:0];
          wtot <= sub_t[WTOT_BITS] ? '0 : sub_t[WTOT_BITS-1:0];
        end
      end
      ST_Q_B: begin
        if (exb_on) begin
          wsum <= sub_w[WSUM_BITS] ? '0 : sub_w[WSUM_BITS-1:0];
          wtot <= sub_t[WTOT_BITS] ? '0 : sub_t[WTOT_BITS-1:0];
        end
      end
      ST_Q_C: begin
        sample_echo <= smp;
        index_value <= '0;
        index_missing <= 1'b1;
        dreq.start <= (wtot != '0);
        dreq.num <= {wsum, 1'b0};
        dreq.den <= wtot;
      end
      ST_Q_DIV: begin
        index_missing <= 1'b0;
        index_value <= (drsp.quo > QUO_BITS'(65536)) ? HI_BITS'(65536)
                                                     : drsp.quo[HI_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  a_div_only_query: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == ST_Q_DIV) else $error("divider done outside query");
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("result while busy");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !c_we && !s_we) else $error("write while idle");
endmodule
